### hw/rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain concurrent check, sampled on the rising clock and quiet while reset is active.
`define PPC_ASSERT(name, clk, rstn, prop) \
	name: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error("ppc checker: assertion failed");

// A stalled item holds its valid and its payload until it is taken.
`define PPC_ASSERT_HOLD(name, clk, rstn, vld, rdy, pay) \
	`PPC_ASSERT(name, clk, rstn, (vld && !rdy) |=> (vld && $stable(pay)))

`endif

### hw/rtl/ppc_pkg.sv
package ppc_pkg;

	localparam int FRAC_BITS = 16;
	localparam int NATTR     = 11;
	localparam int ATTR_W    = 32;
	localparam int DIST_W    = 64;
	localparam int TDATA_W   = NATTR * ATTR_W;
	localparam int T_W       = FRAC_BITS + 1;
	localparam int ITER_W    = $clog2(FRAC_BITS + 1);
	localparam int IDX_W     = $clog2(NATTR);

	// Crossing parameter of exactly one.
	localparam logic [T_W-1:0] T_ONE = T_W'(1) << FRAC_BITS;
	// Largest |d0|+|d1| that counts as a near-parallel edge (below 1e-4).
	localparam logic [DIST_W-1:0] NEAR_MAX =
		((64'd1 << (2 * FRAC_BITS - 2)) - 64'd1) / 64'd10000;

	// Register indexes.
	localparam logic [2:0] REG_PT_X = 3'd0;
	localparam logic [2:0] REG_PT_Y = 3'd1;
	localparam logic [2:0] REG_PT_Z = 3'd2;
	localparam logic [2:0] REG_N_X  = 3'd3;
	localparam logic [2:0] REG_N_Y  = 3'd4;
	localparam logic [2:0] REG_N_Z  = 3'd5;

	// Result end codes.
	localparam logic [1:0] END_MORE    = 2'd0;
	localparam logic [1:0] END_INSIDE  = 2'd1;
	localparam logic [1:0] END_CLIPPED = 2'd2;
	localparam logic [1:0] END_OUTSIDE = 2'd3;

	typedef logic [NATTR-1:0][ATTR_W-1:0] vtx_t;

	typedef struct packed {
		logic [2:0][ATTR_W-1:0] pt;
		logic [2:0][ATTR_W-1:0] n;
	} plane_t;

	typedef struct packed {
		vtx_t              attr;
		logic [DIST_W-1:0] sdist;
		logic              last;
	} item_t;

	typedef struct packed {
		logic              start;
		logic [DIST_W-1:0] da;
		logic [DIST_W-1:0] db;
	} div_req_t;

endpackage

### hw/rtl/ppc_front.sv
module ppc_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [ppc_pkg::TDATA_W-1:0]  s_tdata,
	input  logic                         s_tlast,
	input  ppc_pkg::plane_t              plane,
	output logic                         push,
	output ppc_pkg::item_t               push_item,
	input  logic                         full
);
	import ppc_pkg::*;

	typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

	fstate_t                     state_q;
	logic [1:0]                  cnt_q;
	vtx_t                        vtx_q;
	logic                        last_q;
	logic signed [2*ATTR_W:0]    prod_s1;
	logic signed [2*ATTR_W+2:0]  acc_q;

	logic [ATTR_W-1:0]           p_c, q_c, n_c;
	logic signed [ATTR_W:0]      diff_c;
	logic signed [2*ATTR_W:0]    prod_c;

	// One product of the dot product per cycle: (p - q) * n on one axis.
	always_comb begin
		case (cnt_q)
			2'd0: begin
				p_c = vtx_q[0]; q_c = plane.pt[0]; n_c = plane.n[0];
			end
			2'd1: begin
				p_c = vtx_q[1]; q_c = plane.pt[1]; n_c = plane.n[1];
			end
			2'd2: begin
				p_c = vtx_q[2]; q_c = plane.pt[2]; n_c = plane.n[2];
			end
			default: begin
				p_c = '0; q_c = '0; n_c = '0;
			end
		endcase
		diff_c = $signed({p_c[ATTR_W-1], p_c}) - $signed({q_c[ATTR_W-1], q_c});
		prod_c = diff_c * $signed(n_c);
	end

	assign s_tready        = (state_q == F_IDLE);
	assign push            = (state_q == F_PUSH) && !full;
	assign push_item.attr  = vtx_q;
	// The sum is kept as floor(sum / 4).
	assign push_item.sdist = acc_q[DIST_W+1:2];
	assign push_item.last  = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (s_tvalid) begin
						vtx_q   <= s_tdata;
						last_q  <= s_tlast;
						acc_q   <= '0;
						cnt_q   <= '0;
						state_q <= F_MUL;
					end
				end
				F_MUL: begin
					prod_s1 <= prod_c;
					if (cnt_q != 2'd0)
						acc_q <= acc_q + (2*ATTR_W+3)'(prod_s1);
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd3)
						state_q <= F_PUSH;
				end
				F_PUSH: begin
					if (!full)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/ppc_fifo.sv
module ppc_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  ppc_pkg::item_t  push_item,
	output logic            full,
	input  logic            pop,
	output logic            pop_valid,
	output ppc_pkg::item_t  pop_item
);
	import ppc_pkg::*;

	item_t      slot_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;

	assign full      = (cnt_q == 2'd2);
	assign pop_valid = (cnt_q != 2'd0);
	assign pop_item  = slot_q[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= ~wr_q;
			if (pop)
				rd_q <= ~rd_q;
			if (push && !pop)
				cnt_q <= cnt_q + 2'd1;
			else if (pop && !push)
				cnt_q <= cnt_q - 2'd1;
		end
	end

endmodule

### hw/rtl/ppc_div.sv
module ppc_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ppc_pkg::div_req_t         req,
	output logic                      done,
	output logic [ppc_pkg::T_W-1:0]   t
);
	import ppc_pkg::*;

	typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN, D_DONE} dstate_t;

	dstate_t              state_q;
	logic [DIST_W-1:0]    num_q, den_q, rem_q;
	logic [FRAC_BITS-1:0] quo_q;
	logic [ITER_W-1:0]    iter_q;
	logic [T_W-1:0]       t_q;

	logic [DIST_W-1:0]    mag_a, mag_b;
	logic [DIST_W:0]      two_rem;
	logic                 qbit_c;

	assign mag_a   = req.da[DIST_W-1] ? (~req.da + 1'b1) : req.da;
	assign mag_b   = req.db[DIST_W-1] ? (~req.db + 1'b1) : req.db;
	assign two_rem = {rem_q, 1'b0};
	assign qbit_c  = (two_rem >= {1'b0, den_q});
	assign done    = (state_q == D_DONE);
	assign t       = t_q;

	// Restoring division of |d0| by |d0|+|d1|, one quotient bit per cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			iter_q  <= '0;
		end else begin
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						num_q   <= mag_a;
						den_q   <= mag_a + mag_b;
						state_q <= D_CHECK;
					end
				end
				D_CHECK: begin
					rem_q  <= num_q;
					quo_q  <= '0;
					iter_q <= '0;
					if (den_q <= NEAR_MAX) begin
						t_q     <= '0;
						state_q <= D_DONE;
					end else if (num_q >= den_q) begin
						t_q     <= T_ONE;
						state_q <= D_DONE;
					end else begin
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					quo_q <= {quo_q[FRAC_BITS-2:0], qbit_c};
					if (qbit_c)
						rem_q <= DIST_W'(two_rem - {1'b0, den_q});
					else
						rem_q <= two_rem[DIST_W-1:0];
					iter_q <= iter_q + 1'b1;
					// The last quotient bit lands in t together with the others.
					if (iter_q == ITER_W'(FRAC_BITS - 1)) begin
						t_q     <= {1'b0, quo_q[FRAC_BITS-2:0], qbit_c};
						state_q <= D_DONE;
					end
				end
				D_DONE: begin
					state_q <= D_IDLE;
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/ppc_back.sv
module ppc_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         pop_valid,
	input  ppc_pkg::item_t               pop_item,
	output logic                         pop,
	output ppc_pkg::div_req_t            div_req,
	input  logic                         div_done,
	input  logic [ppc_pkg::T_W-1:0]      div_t,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [ppc_pkg::TDATA_W-1:0]  m_tdata,
	output logic [1:0]                   m_tuser
);
	import ppc_pkg::*;

	localparam int PROD_W = ATTR_W + 1 + T_W + 1;
	localparam int STEP_W = PROD_W - FRAC_BITS;

	typedef enum logic [3:0] {
		B_IDLE, B_START, B_EDGE, B_DIV, B_LERP, B_LERP2,
		B_SEND_X, B_SEND_B, B_DONE, B_DUP, B_MARK
	} bstate_t;

	bstate_t             state_q;
	vtx_t                cur_q, first_q, prev_q, lem_q, xbuf_q, out_q;
	logic [DIST_W-1:0]   dc_q, fd_q, pd_q;
	logic                last_q, have_first_q, clip_q, emit_q, closing_q, sent_q;
	logic [1:0]          code_q, out_code_q;
	logic                ov_q;
	logic [T_W-1:0]      t_q;
	logic [IDX_W-1:0]    k_q;
	logic signed [PROD_W-1:0] prod_s1;

	vtx_t                a_vec, b_vec;
	logic [DIST_W-1:0]   da_c, db_c;
	logic                ain, bin, out_free, load_c, x_last;
	logic [ATTR_W-1:0]   ak, bk;
	logic signed [ATTR_W:0]   diff_c;
	logic signed [PROD_W-1:0] prod_c;
	logic signed [STEP_W:0]   sum_c;
	logic [ATTR_W-1:0]   sat_c;

	// The edge in work: previous to current, or current back to first.
	assign a_vec = closing_q ? cur_q : prev_q;
	assign b_vec = closing_q ? first_q : cur_q;
	assign da_c  = closing_q ? dc_q : pd_q;
	assign db_c  = closing_q ? fd_q : dc_q;
	assign ain   = !da_c[DIST_W-1];
	assign bin   = !db_c[DIST_W-1];

	assign ak     = a_vec[k_q];
	assign bk     = b_vec[k_q];
	assign diff_c = $signed({bk[ATTR_W-1], bk}) - $signed({ak[ATTR_W-1], ak});
	assign prod_c = diff_c * $signed({1'b0, t_q});
	assign sum_c  = $signed(prod_s1[PROD_W-1:FRAC_BITS])
	              + $signed((STEP_W+1)'($signed(ak)));

	always_comb begin
		if (sum_c > $signed((STEP_W+1)'(33'sh0_7fff_ffff)))
			sat_c = 32'h7fff_ffff;
		else if (sum_c < $signed((STEP_W+1)'(-33'sh0_8000_0000)))
			sat_c = 32'h8000_0000;
		else
			sat_c = sum_c[ATTR_W-1:0];
	end

	assign out_free      = !ov_q || m_tready;
	assign load_c        = out_free && (state_q inside {B_SEND_X, B_SEND_B, B_DUP, B_MARK});
	// An outgoing crossing ends the polygon when it is the closing edge, or when
	// it is the edge into the final vertex and the closing edge stays outside.
	assign x_last        = !bin && (closing_q || (last_q && fd_q[DIST_W-1]));
	assign pop           = (state_q == B_IDLE) && pop_valid;
	assign div_req.start = (state_q == B_EDGE) && (ain != bin);
	assign div_req.da    = da_c;
	assign div_req.db    = db_c;
	assign m_tvalid      = ov_q;
	assign m_tdata       = out_q;
	assign m_tuser       = out_code_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= B_IDLE;
			have_first_q <= 1'b0;
			clip_q       <= 1'b0;
			emit_q       <= 1'b0;
			closing_q    <= 1'b0;
			sent_q       <= 1'b0;
			ov_q         <= 1'b0;
			k_q          <= '0;
			code_q       <= END_MORE;
		end else begin
			if (load_c)
				ov_q <= 1'b1;
			else if (m_tready)
				ov_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (pop_valid) begin
						cur_q   <= pop_item.attr;
						dc_q    <= pop_item.sdist;
						last_q  <= pop_item.last;
						state_q <= B_START;
					end
				end
				B_START: begin
					closing_q <= !have_first_q && last_q;
					sent_q    <= 1'b0;
					if (!have_first_q) begin
						first_q      <= cur_q;
						fd_q         <= dc_q;
						prev_q       <= cur_q;
						pd_q         <= dc_q;
						have_first_q <= 1'b1;
						clip_q       <= 1'b0;
						emit_q       <= 1'b0;
						if (last_q) begin
							code_q  <= END_INSIDE;
							state_q <= B_EDGE;
						end else begin
							state_q <= B_IDLE;
						end
					end else begin
						state_q <= B_EDGE;
					end
				end
				B_EDGE: begin
					if (ain && bin)
						state_q <= B_SEND_B;
					else if (!ain && !bin)
						state_q <= B_DONE;
					else
						state_q <= B_DIV;
				end
				B_DIV: begin
					if (div_done) begin
						t_q     <= div_t;
						k_q     <= '0;
						state_q <= B_LERP;
					end
				end
				B_LERP: begin
					prod_s1 <= prod_c;
					state_q <= B_LERP2;
				end
				B_LERP2: begin
					xbuf_q[k_q] <= sat_c;
					if (k_q == IDX_W'(NATTR - 1)) begin
						state_q <= B_SEND_X;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= B_LERP;
					end
				end
				B_SEND_X: begin
					if (out_free) begin
						out_q      <= xbuf_q;
						out_code_q <= x_last ? (closing_q ? code_q : END_CLIPPED) : END_MORE;
						lem_q      <= xbuf_q;
						clip_q     <= 1'b1;
						emit_q     <= 1'b1;
						sent_q     <= 1'b1;
						state_q    <= bin ? B_SEND_B : B_DONE;
					end
				end
				B_SEND_B: begin
					if (out_free) begin
						out_q      <= b_vec;
						out_code_q <= closing_q ? code_q : END_MORE;
						lem_q      <= b_vec;
						emit_q     <= 1'b1;
						sent_q     <= 1'b1;
						state_q    <= B_DONE;
					end
				end
				B_DONE: begin
					if (!closing_q) begin
						prev_q <= cur_q;
						pd_q   <= dc_q;
						if (last_q) begin
							// The code reflects the edges before the closing one.
							code_q    <= clip_q ? END_CLIPPED : END_INSIDE;
							closing_q <= 1'b1;
							state_q   <= B_EDGE;
						end else begin
							state_q <= B_IDLE;
						end
					end else if (sent_q) begin
						have_first_q <= 1'b0;
						clip_q       <= 1'b0;
						emit_q       <= 1'b0;
						state_q      <= B_IDLE;
					end else if (emit_q) begin
						state_q <= B_DUP;
					end else begin
						state_q <= B_MARK;
					end
				end
				B_DUP, B_MARK: begin
					if (out_free) begin
						out_q        <= (state_q == B_DUP) ? lem_q : '0;
						out_code_q   <= (state_q == B_DUP) ? code_q : END_OUTSIDE;
						have_first_q <= 1'b0;
						clip_q       <= 1'b0;
						emit_q       <= 1'b0;
						state_q      <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

### hw/rtl/polygon_plane_clipper_core.sv
// Single-plane polygon clipper. Vertices stream in on the s_ channel, one item per
// vertex, with s_tlast on the final vertex of a polygon. Clipped vertices leave on
// the m_ channel; m_tuser carries the end code (0 more follow, 1 last of an inside
// polygon, 2 last of a clipped polygon, 3 lone marker for an all-outside polygon).
// The user must set the plane (point and normal) through the APB port only while
// the block is idle; the block itself does not enforce this. The front computes the
// signed plane distance with one multiplier and takes no new vertex until it has
// pushed the last one into a two-entry queue to the back. The back takes a vertex,
// then handles the edge to it, which stays inside, stays outside or crosses the
// plane; on a crossing the divider yields one bit of t per cycle and the
// interpolator shares one multiplier across the eleven attributes. The final vertex
// adds the closing edge and, where needed, a repeated vertex or the marker. Reset
// clears the polygon state, empties the queue and loads the default plane z = 0
// with normal +z. When the receiver stalls, the result waits in the output register,
// the back halts at its next result, and the front keeps filling the queue until it
// is full.
module polygon_plane_clipper_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, tex_u, tex_v, col_r, col_g, col_b
	input  logic [ppc_pkg::TDATA_W-1:0]  s_tdata,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic                         s_tlast,
	// out_x, out_y, out_z, out_norm_x, out_norm_y, out_norm_z, out_u, out_v,
	// out_r, out_g, out_b
	output logic [ppc_pkg::TDATA_W-1:0]  m_tdata,
	// end_code
	output logic [1:0]                   m_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [4:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);
	import ppc_pkg::*;

	plane_t   plane_q;
	logic     cfg_wr;
	logic     push, full, pop, pop_valid, div_done;
	item_t    push_item, pop_item;
	div_req_t div_req;
	logic [T_W-1:0] div_t;

	// Configuration registers, one word each at byte address 4 * index.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_q.pt   <= '0;
			plane_q.n[0] <= '0;
			plane_q.n[1] <= '0;
			plane_q.n[2] <= ATTR_W'(64'd1 << FRAC_BITS);
		end else if (cfg_wr) begin
			case (paddr[4:2])
				REG_PT_X: plane_q.pt[0] <= pwdata;
				REG_PT_Y: plane_q.pt[1] <= pwdata;
				REG_PT_Z: plane_q.pt[2] <= pwdata;
				REG_N_X:  plane_q.n[0]  <= pwdata;
				REG_N_Y:  plane_q.n[1]  <= pwdata;
				REG_N_Z:  plane_q.n[2]  <= pwdata;
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_PT_X: prdata = plane_q.pt[0];
			REG_PT_Y: prdata = plane_q.pt[1];
			REG_PT_Z: prdata = plane_q.pt[2];
			REG_N_X:  prdata = plane_q.n[0];
			REG_N_Y:  prdata = plane_q.n[1];
			REG_N_Z:  prdata = plane_q.n[2];
			default:  prdata = '0;
		endcase
	end

	ppc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.plane     (plane_q),
		.push      (push),
		.push_item (push_item),
		.full      (full)
	);

	ppc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_item  (pop_item)
	);

	ppc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.t      (div_t)
	);

	ppc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_item  (pop_item),
		.pop       (pop),
		.div_req   (div_req),
		.div_done  (div_done),
		.div_t     (div_t),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule

### hw/rtl/ppc_checker.sv
`include "assert_macros.svh"

module ppc_checker (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         s_tvalid,
	input logic                         s_tready,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [ppc_pkg::TDATA_W-1:0]  m_tdata,
	input logic [1:0]                   m_tuser,
	input logic                         pready
);
	import ppc_pkg::*;

	// A waiting result keeps its vertex and its end code.
	`PPC_ASSERT_HOLD(a_out_hold, clk, arst_n, m_tvalid, m_tready, {m_tdata, m_tuser})
	// The front is busy computing the distance right after it takes a vertex.
	`PPC_ASSERT(a_front_busy, clk, arst_n, (s_tvalid && s_tready) |=> !s_tready)
	// The all-outside marker carries an all-zero vertex.
	`PPC_ASSERT(a_marker_zero, clk, arst_n, (m_tvalid && m_tuser == END_OUTSIDE) |-> (m_tdata == '0))
	// The register port never inserts wait states.
	`PPC_ASSERT(a_pready, clk, arst_n, pready)

endmodule

bind polygon_plane_clipper_core ppc_checker u_ppc_checker (.*);
